/* hw/rtl/mbq_pkg.sv */
// Shared types and constants of the multichannel biquad unit.
// Holds field widths, register indexes, sequencer step codes and the history word.
// No dependencies.
package mbq_pkg;

   localparam int SAMPLE_W  = 24;
   localparam int COEF_W    = 32;
   localparam int FRAC_BITS = 28;
   localparam int PROD_W    = SAMPLE_W + COEF_W;
   localparam int ACC_W     = PROD_W + 4;
   localparam int ROUND_W   = ACC_W - FRAC_BITS;
   localparam int CHAN_W    = 3;
   localparam int CHAN_EXT_W = 7;

   localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 24'sh7F_FFFF;
   localparam logic signed [SAMPLE_W-1:0] OUT_MIN = -24'sh80_0000;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));

   localparam logic signed [COEF_W-1:0] FEED_GAIN_0_RESET = 32'sh1000_0000;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_FEED_GAIN_0 = 3'd0;
   localparam logic [2:0] REG_FEED_GAIN_1 = 3'd1;
   localparam logic [2:0] REG_FEED_GAIN_2 = 3'd2;
   localparam logic [2:0] REG_BACK_GAIN_1 = 3'd3;
   localparam logic [2:0] REG_BACK_GAIN_2 = 3'd4;

   // Sequencer steps of one request, in the order they run.
   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_MUL_G0,
      STEP_MUL_G1,
      STEP_MUL_G2,
      STEP_MUL_H1,
      STEP_MUL_H2,
      STEP_DRAIN,
      STEP_FINISH
   } step_type;

   // One channel's delay line as it is kept in the history memory.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x1;
      logic signed [SAMPLE_W-1:0] x2;
      logic signed [SAMPLE_W-1:0] y1;
      logic signed [SAMPLE_W-1:0] y2;
   } hist_type;

endpackage

/* hw/rtl/multichannel_biquad_df1_unit.sv */
// Top level of the multichannel Direct Form 1 biquad filter.
// Depends on mbq_pkg and mbq_ram.

// Each request carries a signed 24-bit sample and a channel number; the unit returns one
// filtered sample y = g0*x + g1*x1 + g2*x2 - h1*y1 - h2*y2 with the five Q3.28 gains
// taken from the configuration registers, rounded half up and saturated to 24 bits, and
// a clipped flag. A request passes through the history read, five steps through one
// shared 32x24 multiplier, one accumulate and a final step to round, saturate and write
// the history back; that final step waits while an earlier result is still held in the
// result register. A new request is taken as soon as the previous one has finished, even
// while its result still waits. The channel histories live in one memory that is not
// swept at reset; per-channel valid flags make an unwritten channel read as an all-zero
// history, so the unit is ready as soon as reset is released. A channel number at or
// above CHANNELS filters against a zero history and leaves all histories untouched.
// Gains are written through an APB-style port at byte addresses 0, 4, 8, 12 and 16; the
// user must write them only while the unit is idle, which the unit itself leaves unchecked.
module multichannel_biquad_df1_unit #(
   parameter int CHANNELS = 8
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [23:0] req_sample_in,
   input  logic [2:0]  req_channel_sel,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [23:0] rsp_sample_out,
   output logic        rsp_clipped,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Gain registers.
   logic signed [mbq_pkg::COEF_W-1:0] feed_gain_0_ff, feed_gain_1_ff, feed_gain_2_ff;
   logic signed [mbq_pkg::COEF_W-1:0] back_gain_1_ff, back_gain_2_ff;

   logic       csr_write;
   logic [2:0] csr_index;

   assign pready    = 1'b1;
   assign csr_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         feed_gain_0_ff <= mbq_pkg::FEED_GAIN_0_RESET;
         feed_gain_1_ff <= '0;
         feed_gain_2_ff <= '0;
         back_gain_1_ff <= '0;
         back_gain_2_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            mbq_pkg::REG_FEED_GAIN_0: feed_gain_0_ff <= pwdata;
            mbq_pkg::REG_FEED_GAIN_1: feed_gain_1_ff <= pwdata;
            mbq_pkg::REG_FEED_GAIN_2: feed_gain_2_ff <= pwdata;
            mbq_pkg::REG_BACK_GAIN_1: back_gain_1_ff <= pwdata;
            mbq_pkg::REG_BACK_GAIN_2: back_gain_2_ff <= pwdata;
            default: ;
         endcase
      end
   end

   // Read-back of the gains; unused addresses read as zero.
   always_comb begin
      unique case (csr_index)
         mbq_pkg::REG_FEED_GAIN_0: prdata = feed_gain_0_ff;
         mbq_pkg::REG_FEED_GAIN_1: prdata = feed_gain_1_ff;
         mbq_pkg::REG_FEED_GAIN_2: prdata = feed_gain_2_ff;
         mbq_pkg::REG_BACK_GAIN_1: prdata = back_gain_1_ff;
         mbq_pkg::REG_BACK_GAIN_2: prdata = back_gain_2_ff;
         default:                  prdata = '0;
      endcase
   end

   // Request intake. The unit takes a request whenever no earlier one is still in the
   // sequencer, so the history write of one request always lands before the read of the
   // next and no forwarding is needed.
   mbq_pkg::step_type          step_ff, step_in;
   logic                       busy;
   logic                       req_take;
   logic [mbq_pkg::CHAN_EXT_W-1:0] chan_ext;
   logic                       chan_ok;
   logic [ADDR_W-1:0]          chan_addr;

   assign busy      = (step_ff != mbq_pkg::STEP_IDLE);
   assign req_stall = busy;
   assign req_take  = req_valid && !busy;
   assign chan_ext  = {{(mbq_pkg::CHAN_EXT_W - mbq_pkg::CHAN_W){1'b0}}, req_channel_sel};
   assign chan_ok   = (chan_ext < mbq_pkg::CHAN_EXT_W'(CHANNELS));
   assign chan_addr = chan_ext[ADDR_W-1:0];

   logic signed [mbq_pkg::SAMPLE_W-1:0] x_ff;
   logic [ADDR_W-1:0]                   addr_ff;
   logic                                chan_ok_ff;
   logic                                hist_ok_ff;
   logic [CHANNELS-1:0]                 filled_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         x_ff    <= req_sample_in;
         addr_ff <= chan_addr;
      end
   end

   // History memory and the flags that say which channels hold written data.
   mbq_pkg::hist_type ram_rd, hist, hist_wr;
   logic              ram_wr_en;
   logic              finish;

   mbq_ram #(
      .WIDTH ($bits(mbq_pkg::hist_type)),
      .DEPTH (CHANNELS),
      .ADDR_W(ADDR_W)
   ) u_hist_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(addr_ff),
      .wr_data(hist_wr),
      .rd_en  (req_take),
      .rd_addr(chan_addr),
      .rd_data(ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff  <= '0;
         chan_ok_ff <= 1'b0;
         hist_ok_ff <= 1'b0;
      end else begin
         if (req_take) begin
            chan_ok_ff <= chan_ok;
            hist_ok_ff <= chan_ok ? filled_ff[chan_addr] : 1'b0;
         end
         if (ram_wr_en) begin
            filled_ff[addr_ff] <= 1'b1;
         end
      end
   end

   // An unwritten channel, or one beyond the channel count, has an all-zero history.
   assign hist = hist_ok_ff ? ram_rd : '0;

   // Multiply-accumulate sequencer: one product a step, accumulated one step later.
   logic signed [mbq_pkg::COEF_W-1:0]   coef_sel;
   logic signed [mbq_pkg::SAMPLE_W-1:0] opnd_sel;
   logic signed [mbq_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic                                prod_sub_ff, prod_sub_in;
   logic signed [mbq_pkg::ACC_W-1:0]    acc_ff, acc_in, acc_base;

   always_comb begin
      unique case (step_ff)
         mbq_pkg::STEP_MUL_G0: begin
            coef_sel = feed_gain_0_ff;
            opnd_sel = x_ff;
         end
         mbq_pkg::STEP_MUL_G1: begin
            coef_sel = feed_gain_1_ff;
            opnd_sel = hist.x1;
         end
         mbq_pkg::STEP_MUL_G2: begin
            coef_sel = feed_gain_2_ff;
            opnd_sel = hist.x2;
         end
         mbq_pkg::STEP_MUL_H1: begin
            coef_sel = back_gain_1_ff;
            opnd_sel = hist.y1;
         end
         mbq_pkg::STEP_MUL_H2: begin
            coef_sel = back_gain_2_ff;
            opnd_sel = hist.y2;
         end
         default: begin
            coef_sel = '0;
            opnd_sel = '0;
         end
      endcase
   end

   assign prod_in     = coef_sel * opnd_sel;
   assign prod_sub_in = (step_ff == mbq_pkg::STEP_MUL_H1) || (step_ff == mbq_pkg::STEP_MUL_H2);

   // The rounding half is folded into the first accumulation.
   assign acc_base = (step_ff == mbq_pkg::STEP_MUL_G1) ? mbq_pkg::ROUND_HALF : acc_ff;
   assign acc_in   = prod_sub_ff ? acc_base - mbq_pkg::ACC_W'(prod_ff)
                                 : acc_base + mbq_pkg::ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      prod_sub_ff <= prod_sub_in;
      if ((step_ff >= mbq_pkg::STEP_MUL_G1) && (step_ff <= mbq_pkg::STEP_DRAIN)) begin
         if (step_ff != mbq_pkg::STEP_MUL_G0) begin
            acc_ff <= acc_in;
         end
      end
   end

   // Rounding and saturation: the arithmetic shift floors, so halves round upward.
   logic signed [mbq_pkg::ROUND_W-1:0]  rounded;
   logic signed [mbq_pkg::SAMPLE_W-1:0] y_sat;
   logic                                clip;

   assign rounded = mbq_pkg::ROUND_W'(acc_ff >>> mbq_pkg::FRAC_BITS);

   always_comb begin
      priority if (rounded > mbq_pkg::ROUND_W'(mbq_pkg::OUT_MAX)) begin
         y_sat = mbq_pkg::OUT_MAX;
         clip  = 1'b1;
      end else if (rounded < mbq_pkg::ROUND_W'(mbq_pkg::OUT_MIN)) begin
         y_sat = mbq_pkg::OUT_MIN;
         clip  = 1'b1;
      end else begin
         y_sat = mbq_pkg::SAMPLE_W'(rounded);
         clip  = 1'b0;
      end
   end

   // The last step waits while an earlier result is still held in the result register.
   logic rsp_valid_ff;
   logic rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (step_ff == mbq_pkg::STEP_FINISH) && rsp_free;
   assign ram_wr_en = finish && chan_ok_ff;

   always_comb begin
      hist_wr.x1 = x_ff;
      hist_wr.x2 = hist.x1;
      hist_wr.y1 = y_sat;
      hist_wr.y2 = hist.y1;
   end

   always_comb begin
      step_in = step_ff;
      if (req_take) begin
         step_in = mbq_pkg::STEP_MUL_G0;
      end else if (step_ff == mbq_pkg::STEP_FINISH) begin
         if (rsp_free) begin
            step_in = mbq_pkg::STEP_IDLE;
         end
      end else if (busy) begin
         step_in = mbq_pkg::step_type'(step_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= mbq_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // Result register.
   logic signed [mbq_pkg::SAMPLE_W-1:0] rsp_sample_ff;
   logic                                rsp_clipped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_sample_ff  <= y_sat;
         rsp_clipped_ff <= clip;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clipped_ff;

endmodule

/* hw/rtl/mbq_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module mbq_ram #(
   parameter int WIDTH  = 96,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* bench/testbench.sv */
// Self-checking bench for the multichannel Direct Form 1 biquad unit.
// Holds a scoreboard class with its own filter predictor, the request, result and
// register drivers, and the test sequence. Depends on mbq_pkg and the unit's RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHANNELS = 8;

   // Register slots above the last gain decode to nothing; writes there are dropped.
   localparam logic [2:0] REG_UNUSED_FIRST = mbq_pkg::REG_BACK_GAIN_2 + 3'd1;
   localparam int ADDR_SLOTS = 8;

   // Gain values used for the extreme and rounding phases.
   localparam logic signed [mbq_pkg::COEF_W-1:0] GAIN_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [mbq_pkg::COEF_W-1:0] GAIN_MIN  = -32'sh8000_0000;
   localparam logic signed [mbq_pkg::COEF_W-1:0] GAIN_HALF = 32'sh0800_0000;
   localparam logic signed [mbq_pkg::COEF_W-1:0] GAIN_ZERO = 32'sh0;

   // Scoreboard: keeps its own copy of the gains and of each channel's delay line,
   // filters every accepted request, and compares each result against the oldest
   // filtered sample still waiting.
   class df1_scoreboard;
      typedef struct {
         logic signed [mbq_pkg::SAMPLE_W-1:0] sample;
         logic                                clip;
      } filtered_type;

      logic signed [mbq_pkg::COEF_W-1:0]   gain [5];
      logic signed [mbq_pkg::SAMPLE_W-1:0] x_prev [CHANNELS];
      logic signed [mbq_pkg::SAMPLE_W-1:0] x_older [CHANNELS];
      logic signed [mbq_pkg::SAMPLE_W-1:0] y_prev [CHANNELS];
      logic signed [mbq_pkg::SAMPLE_W-1:0] y_older [CHANNELS];
      filtered_type                        expected_outputs [$];
      int                                  errors;
      int                                  clip_count;

      function new();
         gain[mbq_pkg::REG_FEED_GAIN_0] = mbq_pkg::FEED_GAIN_0_RESET;
         gain[mbq_pkg::REG_FEED_GAIN_1] = GAIN_ZERO;
         gain[mbq_pkg::REG_FEED_GAIN_2] = GAIN_ZERO;
         gain[mbq_pkg::REG_BACK_GAIN_1] = GAIN_ZERO;
         gain[mbq_pkg::REG_BACK_GAIN_2] = GAIN_ZERO;
         foreach (x_prev[i]) begin
            x_prev[i] = '0;
            x_older[i] = '0;
            y_prev[i] = '0;
            y_older[i] = '0;
         end
         errors = 0;
         clip_count = 0;
      endfunction

      function void set_gain(logic [2:0] idx, logic [31:0] value);
         if (idx <= mbq_pkg::REG_BACK_GAIN_2)
            gain[idx] = value;
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction

      // Filters one accepted request and queues the sample the unit should return.
      function void note_request(logic signed [mbq_pkg::SAMPLE_W-1:0] x,
                                 logic [mbq_pkg::CHAN_W-1:0] ch);
         logic signed [mbq_pkg::SAMPLE_W-1:0] x1, x2, y1, y2;
         longint                              acc;
         longint                              rounded;
         filtered_type                        res;
         bit                                  in_range;
         in_range = (ch < CHANNELS);
         x1 = in_range ? x_prev[ch] : '0;
         x2 = in_range ? x_older[ch] : '0;
         y1 = in_range ? y_prev[ch] : '0;
         y2 = in_range ? y_older[ch] : '0;
         // Every product is exact and the sum needs no more than 60 bits.
         acc = longint'(gain[mbq_pkg::REG_FEED_GAIN_0]) * longint'(x)
             + longint'(gain[mbq_pkg::REG_FEED_GAIN_1]) * longint'(x1)
             + longint'(gain[mbq_pkg::REG_FEED_GAIN_2]) * longint'(x2)
             - longint'(gain[mbq_pkg::REG_BACK_GAIN_1]) * longint'(y1)
             - longint'(gain[mbq_pkg::REG_BACK_GAIN_2]) * longint'(y2);
         // Add one half and floor, so ties go toward plus infinity.
         rounded = (acc + (64'sd1 <<< (mbq_pkg::FRAC_BITS - 1))) >>> mbq_pkg::FRAC_BITS;
         res.clip = 1'b0;
         if (rounded > longint'(mbq_pkg::OUT_MAX)) begin
            rounded = longint'(mbq_pkg::OUT_MAX);
            res.clip = 1'b1;
         end
         if (rounded < longint'(mbq_pkg::OUT_MIN)) begin
            rounded = longint'(mbq_pkg::OUT_MIN);
            res.clip = 1'b1;
         end
         res.sample = mbq_pkg::SAMPLE_W'(rounded);
         if (in_range) begin
            x_older[ch] = x_prev[ch];
            x_prev[ch] = x;
            y_older[ch] = y_prev[ch];
            y_prev[ch] = res.sample;
         end
         expected_outputs.push_back(res);
      endfunction

      function void check_response(logic signed [mbq_pkg::SAMPLE_W-1:0] sample,
                                   logic clip);
         filtered_type exp_res;
         if (expected_outputs.size() == 0) begin
            $error("result with no request outstanding: sample_out %0d clipped %0b",
                   sample, clip);
            errors++;
            return;
         end
         exp_res = expected_outputs.pop_front();
         if (clip === 1'b1)
            clip_count++;
         if (sample !== exp_res.sample) begin
            $error("sample_out: expected %0d, actual %0d", exp_res.sample, sample);
            errors++;
         end
         if (clip !== exp_res.clip) begin
            $error("clipped: expected %0b, actual %0b", exp_res.clip, clip);
            errors++;
         end
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic signed [mbq_pkg::SAMPLE_W-1:0] req_sample_in;
   logic [mbq_pkg::CHAN_W-1:0]          req_channel_sel;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic signed [mbq_pkg::SAMPLE_W-1:0] rsp_sample_out;
   logic                                rsp_clipped;
   logic                                psel;
   logic                                penable;
   logic                                pwrite;
   logic [4:0]                          paddr;
   logic [31:0]                         pwdata;
   logic [31:0]                         prdata;
   logic                                pready;

   df1_scoreboard sb = new();

   // Random idling on both sides is switched on and off in stretches by the sequence.
   bit idle_on;
   // A nonzero value asks the result side for one long hold-off of that many cycles.
   int rsp_hold_cycles;
   int request_count;
   int gain_settings;

   multichannel_biquad_df1_unit #(
      .CHANNELS(CHANNELS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .req_channel_sel(req_channel_sel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // The run ends here if the unit stops moving; the budget is many times the
   // slowest legal run.
   initial begin
      #2_000_000;
      $display("timeout waiting for the unit");
      $display("end of test: mismatches");
      $finish;
   end

   // Offers one request after a random gap and returns at the edge that accepts it.
   // With no gap, valid stays high from the previous request, so it gets a single
   // assignment in that time step.
   task automatic send_request(input logic signed [mbq_pkg::SAMPLE_W-1:0] s,
                               input logic [mbq_pkg::CHAN_W-1:0] ch);
      int gap;
      gap = idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= s;
      req_channel_sel <= ch;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(s, ch);
      request_count++;
   endtask

   // Stops offering requests and waits until every filtered sample has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // One APB write: a setup phase, the access phase held until pready, then an idle phase
   // so that back-to-back writes never drive the bus twice in one time step.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sb.set_gain(idx, value);
      @(posedge clock);
   endtask

   task automatic load_gains(input logic signed [mbq_pkg::COEF_W-1:0] g0, g1, g2, h1, h2);
      csr_write(mbq_pkg::REG_FEED_GAIN_0, g0);
      csr_write(mbq_pkg::REG_FEED_GAIN_1, g1);
      csr_write(mbq_pkg::REG_FEED_GAIN_2, g2);
      csr_write(mbq_pkg::REG_BACK_GAIN_1, h1);
      csr_write(mbq_pkg::REG_BACK_GAIN_2, h2);
      gain_settings++;
   endtask

   // Full-range noise for half the draws; audio-like values near zero and the rails for the rest.
   function automatic logic signed [mbq_pkg::SAMPLE_W-1:0] draw_sample();
      case ($urandom_range(0, 9))
         0: return mbq_pkg::OUT_MAX;
         1: return mbq_pkg::OUT_MIN;
         2, 3, 4: return mbq_pkg::SAMPLE_W'($signed($urandom_range(0, 4000)) - 2000);
         default: return mbq_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   // Result side: draws a stall before each result, serves any long hold-off the
   // sequence asks for, and then waits for the result to be taken.
   initial begin : result_sink
      int wait_cycles;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            wait_cycles = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            wait_cycles = idle_on ? $urandom_range(0, 11) : 0;
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (reset || rsp_valid !== 1'b1);
      end
   end

   // Every result taken at an edge is checked against the oldest filtered sample.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_response(rsp_sample_out, rsp_clipped);
   end

   initial begin : sequence_main
      int kind;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sample_in <= '0;
      req_channel_sel <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      idle_on = 1'b1;
      rsp_hold_cycles = 0;
      request_count = 0;
      gain_settings = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Gains as left by reset pass the input through, so the rails and the values
      // around zero must come back unchanged on any channel.
      send_request(mbq_pkg::OUT_MAX, 3'd0);
      send_request(mbq_pkg::OUT_MIN, 3'd1);
      send_request(24'sd0, 3'd2);
      send_request(-24'sd1, 3'd3);
      send_request(24'sd1, 3'd4);
      send_request(mbq_pkg::OUT_MAX, 3'd7);
      drain();

      // A gain of one half puts odd inputs exactly on a tie; ties must round up,
      // toward plus infinity, for both signs. Writes to the empty register slots
      // that follow must leave the gains alone.
      load_gains(GAIN_HALF, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO);
      for (int r = REG_UNUSED_FIRST; r < ADDR_SLOTS; r++)
         csr_write(3'(r), $urandom);
      send_request(24'sd1, 3'd5);
      send_request(-24'sd1, 3'd5);
      send_request(24'sd3, 3'd6);
      send_request(-24'sd3, 3'd6);
      drain();

      // Largest gains with the feedback terms at the negative rail: every product
      // adds up, so the sum runs far past both output limits and saturates.
      load_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MIN, GAIN_MIN);
      send_request(mbq_pkg::OUT_MAX, 3'd0);
      send_request(mbq_pkg::OUT_MAX, 3'd0);
      send_request(mbq_pkg::OUT_MAX, 3'd0);
      send_request(mbq_pkg::OUT_MIN, 3'd1);
      send_request(mbq_pkg::OUT_MIN, 3'd1);
      send_request(mbq_pkg::OUT_MIN, 3'd1);
      drain();

      load_gains(GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN);
      send_request(mbq_pkg::OUT_MAX, 3'd2);
      send_request(mbq_pkg::OUT_MAX, 3'd2);
      send_request(mbq_pkg::OUT_MIN, 3'd3);
      send_request(mbq_pkg::OUT_MIN, 3'd3);
      drain();

      // Random part: six gain settings of about a hundred requests each, cycling
      // through a stable low-pass, fully random gains and small random gains.
      // Channels interleave at random so every delay line is exercised.
      for (int set_idx = 0; set_idx < 6; set_idx++) begin
         kind = set_idx % 3;
         case (kind)
            0: load_gains(32'sd18119393, 32'sd36238786, 32'sd18119393,
                          -32'sd306821726, 32'sd110810157);
            1: load_gains($urandom, $urandom, $urandom, $urandom, $urandom);
            default: load_gains(
               mbq_pkg::COEF_W'($signed($urandom_range(0, 1 << 28)) - (1 << 27)),
               mbq_pkg::COEF_W'($signed($urandom_range(0, 1 << 28)) - (1 << 27)),
               mbq_pkg::COEF_W'($signed($urandom_range(0, 1 << 28)) - (1 << 27)),
               mbq_pkg::COEF_W'($signed($urandom_range(0, 1 << 29)) - (1 << 28)),
               mbq_pkg::COEF_W'($signed($urandom_range(0, 1 << 28)) - (1 << 27)));
         endcase
         for (int j = 0; j < 100; j++) begin
            if (j % 25 == 0)
               idle_on = ($urandom_range(0, 3) != 0);
            // In the second setting the result side holds off for a long stretch
            // while requests keep coming back to back, so the unit fills and has
            // to stall its input; later the sender waits for a full drain.
            if (set_idx == 1 && j == 30) begin
               idle_on = 1'b0;
               rsp_hold_cycles = 300;
            end
            if (set_idx == 1 && j == 60)
               drain();
            send_request(draw_sample(), mbq_pkg::CHAN_W'($urandom_range(0, CHANNELS - 1)));
         end
         drain();
      end

      // Everything has been returned; keep the clock running so that any stray result
      // shows before the verdict.
      idle_on = 1'b0;
      repeat (20) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d filtered samples never returned", sb.pending());
         sb.errors++;
      end
      $display("covered %0d requests on %0d channels over %0d gain settings,",
               request_count, CHANNELS, gain_settings);
      $display("with %0d saturated results and %0d errors", sb.clip_count, sb.errors);
      if (sb.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
